// ----- rtl/core/rpn_pkg.sv -----
// Shared types and constants of the postfix expression evaluator.
// No dependencies.
`default_nettype none

package rpn_pkg;

  localparam int DEPTH_W = 7;

  localparam logic [7:0] SYM_ADD  = 8'h2B;
  localparam logic [7:0] SYM_SUB  = 8'h2D;
  localparam logic [7:0] SYM_MUL  = 8'h2A;
  localparam logic [7:0] SYM_DIV  = 8'h2F;
  localparam logic [7:0] SYM_ZERO = 8'h30;

  localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_POPT  = 9'b000000010,
    S_POPN  = 9'b000000100,
    S_EXEC  = 9'b000001000,
    S_MULR  = 9'b000010000,
    S_DIV   = 9'b000100000,
    S_PUSH  = 9'b001000000,
    S_TOPRD = 9'b010000000,
    S_FIN   = 9'b100000000
  } state_t;

endpackage

`default_nettype wire

// ----- rtl/core/rpn_if.sv -----
// Handshake channels of the postfix expression evaluator: symbols in, results out.
// Uses rpn_pkg for the depth width.
`default_nettype none

interface rpn_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       last;

  modport source (output valid, symbol, last, input ready);
  modport sink (input valid, symbol, last, output ready);
endinterface

interface rpn_out_if;
  logic                           valid;
  logic                           ready;
  logic signed [31:0]             value;
  logic                           is_final;
  logic [rpn_pkg::DEPTH_W-1:0]    depth;
  logic                           underflow;
  logic                           overflow;
  logic                           div_by_zero;

  modport source (output valid, value, is_final, depth, underflow, overflow, div_by_zero,
                  input ready);
  modport sink (input valid, value, is_final, depth, underflow, overflow, div_by_zero,
                output ready);
endinterface

`default_nettype wire

// ----- rtl/core/rpn_div.sv -----
// Radix-2 restoring divider: (a * 2^FRAC_BITS) / b, truncated toward zero, saturated.
// Depends on rpn_pkg. One quotient bit per cycle; the quotient is 32 + FRAC_BITS bits wide.
`default_nettype none

module rpn_div #(
  parameter int FRAC_BITS = 16
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                start,
  input  wire signed [31:0]  dividend,
  input  wire signed [31:0]  divisor,
  output logic               done,
  output logic signed [31:0] quo
);

  localparam int QW = 32 + FRAC_BITS;
  localparam int IW = $clog2(QW + 1);
  localparam logic [QW-1:0] POS_LIM = QW'(32'h7FFF_FFFF);
  localparam logic [QW-1:0] NEG_LIM = QW'(32'h8000_0000);

  logic [31:0]   rem;
  logic [QW-1:0] q;
  logic [31:0]   dmag;
  logic          neg;
  logic [IW-1:0] iter;
  logic          run;
  logic [32:0]   trial;
  logic          ge;

  function automatic logic [31:0] abs32(input logic signed [31:0] x);
    return x[31] ? 32'(-x) : 32'(x);
  endfunction

  assign trial = {rem, q[QW-1]};
  assign ge    = trial >= {1'b0, dmag};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      dmag <= abs32(divisor);
      q    <= QW'(abs32(dividend)) << FRAC_BITS;
      rem  <= '0;
      neg  <= dividend[31] ^ divisor[31];
      iter <= IW'(QW);
      run  <= 1'b1;
      done <= 1'b0;
    end else if (run) begin
      rem  <= ge ? 32'(trial - {1'b0, dmag}) : trial[31:0];
      q    <= {q[QW-2:0], ge};
      iter <= iter - 1'b1;
      done <= (iter == IW'(1));
      if (iter == IW'(1)) begin
        run <= 1'b0;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_comb begin
    if (!neg) begin
      quo = (q > POS_LIM) ? rpn_pkg::VAL_MAX : 32'(q);
    end else begin
      quo = (q > NEG_LIM) ? rpn_pkg::VAL_MIN : 32'(-q[31:0]);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/postfix_expression_evaluator_unit.sv -----
// Postfix expression evaluator: signed fixed-point stack calculator.
// Depends on rpn_pkg, rpn_if (rpn_in_if, rpn_out_if) and rpn_div.
//
// Usage: one expression character enters per item on "symbols" (symbol, last).
// '+' '-' '*' '/' pop the top t, then the next n, and push t op n; any other code
// pushes (code - 48) in fixed point. With last set the top is popped and given
// as the final result (is_final). One result item per input item on "results",
// carrying value, depth and the underflow/overflow/div_by_zero flags.
// The stack sits in a single-port synchronous memory of STACK_DEPTH words;
// each pop is one memory read into a registered output.
// From accept to result valid, an operand passes PUSH and FIN; + and - pass
// POPT, POPN, EXEC, PUSH, FIN; * adds MULR, / waits in DIV (one quotient bit
// per cycle in the divider); a full stack on push adds TOPRD. Items are taken
// one at a time; the next is accepted the cycle after the result is registered.
// If the receiver stalls, the result waits in the output register and the
// block holds the following item's result until that one is taken.
// Reset empties the stack at once; stack contents are not cleared.
`default_nettype none

module postfix_expression_evaluator_unit #(
  parameter int STACK_DEPTH = 64,
  parameter int FRAC_BITS   = 16
) (
  input wire          clk,
  input wire          rst,
  rpn_in_if.sink      symbols,
  rpn_out_if.source   results
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int DW = rpn_pkg::DEPTH_W;
  localparam logic signed [31:0] NEG_ONE = -(32'sd1 <<< FRAC_BITS);
  localparam logic [63:0] FRAC_MASK = (64'd1 << FRAC_BITS) - 64'd1;

  rpn_pkg::state_t state;

  logic [31:0]        mem [STACK_DEPTH];
  logic signed [31:0] mem_q;
  logic               mem_we;
  logic               mem_re;
  logic [AW-1:0]      mem_wa;
  logic [AW-1:0]      mem_ra;

  logic [CW-1:0]      cnt;
  logic [CW-1:0]      cnt_m1;
  logic [7:0]         sym_r;
  logic               last_r;
  logic               rd_pend;
  logic signed [31:0] t_r;
  logic signed [31:0] v_r;
  logic signed [31:0] top_r;
  logic signed [63:0] prod_r;
  logic               uf, of, dz;
  logic signed [31:0] nv;
  logic               has_room;
  logic               is_op;
  logic               div_start;
  logic               div_done;
  logic signed [31:0] div_q;
  logic               out_free;

  function automatic logic signed [31:0] sat33(input logic signed [32:0] x);
    if (x > 33'sh0_7FFF_FFFF) return rpn_pkg::VAL_MAX;
    if (x < -33'sh0_8000_0000) return rpn_pkg::VAL_MIN;
    return x[31:0];
  endfunction

  function automatic logic signed [31:0] mul_sat(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = p >>> FRAC_BITS;
    if (p[63] && ((p & FRAC_MASK) != 64'd0)) s = s + 64'sd1;
    if (s > 64'sh7FFF_FFFF) return rpn_pkg::VAL_MAX;
    if (s < -64'sh8000_0000) return rpn_pkg::VAL_MIN;
    return s[31:0];
  endfunction

  assign cnt_m1   = cnt - 1'b1;
  assign has_room = cnt < CW'(STACK_DEPTH);
  assign nv       = rd_pend ? mem_q : NEG_ONE;
  assign is_op    = (symbols.symbol == rpn_pkg::SYM_ADD) || (symbols.symbol == rpn_pkg::SYM_SUB)
                 || (symbols.symbol == rpn_pkg::SYM_MUL) || (symbols.symbol == rpn_pkg::SYM_DIV);
  assign out_free = !results.valid || results.ready;
  assign symbols.ready = (state == rpn_pkg::S_IDLE);

  assign mem_re = (((state == rpn_pkg::S_POPT) || (state == rpn_pkg::S_POPN)) && (cnt != '0))
               || ((state == rpn_pkg::S_PUSH) && !has_room);
  assign mem_ra = cnt_m1[AW-1:0];
  assign mem_we = (state == rpn_pkg::S_PUSH) && has_room;
  assign mem_wa = cnt[AW-1:0];

  assign div_start = (state == rpn_pkg::S_EXEC) && (sym_r == rpn_pkg::SYM_DIV) && (nv != 32'sd0);

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= v_r;
    if (mem_re) mem_q <= mem[mem_ra];
  end

  rpn_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (t_r),
    .divisor  (nv),
    .done     (div_done),
    .quo      (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= rpn_pkg::S_IDLE;
      cnt           <= '0;
      rd_pend       <= 1'b0;
      results.valid <= 1'b0;
    end else begin
      // the finish state reloads valid itself
      if (results.valid && results.ready && (state != rpn_pkg::S_FIN)) results.valid <= 1'b0;
      case (state)
        rpn_pkg::S_IDLE: begin
          if (symbols.valid) begin
            sym_r  <= symbols.symbol;
            last_r <= symbols.last;
            uf     <= 1'b0;
            of     <= 1'b0;
            dz     <= 1'b0;
            if (is_op) begin
              state <= rpn_pkg::S_POPT;
            end else begin
              // wraps to 32 bits, unlike the product, which saturates
              v_r   <= 32'(signed'({1'b0, symbols.symbol}) - signed'({1'b0, rpn_pkg::SYM_ZERO}))
                       <<< FRAC_BITS;
              state <= rpn_pkg::S_PUSH;
            end
          end
        end
        rpn_pkg::S_POPT: begin
          rd_pend <= (cnt != '0);
          if (cnt != '0) cnt <= cnt_m1;
          state <= rpn_pkg::S_POPN;
        end
        rpn_pkg::S_POPN: begin
          t_r <= nv;
          if (!rd_pend) uf <= 1'b1;
          rd_pend <= (cnt != '0);
          if (cnt != '0) cnt <= cnt_m1;
          state <= rpn_pkg::S_EXEC;
        end
        rpn_pkg::S_EXEC: begin
          if (!rd_pend) uf <= 1'b1;
          state <= rpn_pkg::S_PUSH;
          case (sym_r)
            rpn_pkg::SYM_ADD: v_r <= sat33(33'(t_r) + 33'(nv));
            rpn_pkg::SYM_SUB: v_r <= sat33(33'(t_r) - 33'(nv));
            rpn_pkg::SYM_MUL: begin
              prod_r <= 64'(t_r) * 64'(nv);
              state  <= rpn_pkg::S_MULR;
            end
            default: begin
              if (nv == 32'sd0) begin
                dz  <= 1'b1;
                v_r <= t_r[31] ? rpn_pkg::VAL_MIN : rpn_pkg::VAL_MAX;
              end else begin
                state <= rpn_pkg::S_DIV;
              end
            end
          endcase
        end
        rpn_pkg::S_MULR: begin
          v_r   <= mul_sat(prod_r);
          state <= rpn_pkg::S_PUSH;
        end
        rpn_pkg::S_DIV: begin
          if (div_done) begin
            v_r   <= div_q;
            state <= rpn_pkg::S_PUSH;
          end
        end
        rpn_pkg::S_PUSH: begin
          if (has_room) begin
            cnt   <= cnt + 1'b1;
            top_r <= v_r;
            state <= rpn_pkg::S_FIN;
          end else begin
            // full: item dropped, top comes back from memory
            of    <= 1'b1;
            state <= rpn_pkg::S_TOPRD;
          end
        end
        rpn_pkg::S_TOPRD: begin
          top_r <= mem_q;
          state <= rpn_pkg::S_FIN;
        end
        rpn_pkg::S_FIN: begin
          if (out_free) begin
            results.valid       <= 1'b1;
            results.value       <= top_r;
            results.is_final    <= last_r;
            results.underflow   <= uf;
            results.overflow    <= of;
            results.div_by_zero <= dz;
            if (last_r) begin
              cnt           <= cnt_m1;
              results.depth <= DW'(cnt_m1);
            end else begin
              results.depth <= DW'(cnt);
            end
            state <= rpn_pkg::S_IDLE;
          end
        end
        default: state <= rpn_pkg::S_IDLE;
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    symbols.valid && symbols.ready |=> !symbols.ready)
    else $error("second item taken while one is in work");

  a_port_excl: assert property (@(posedge clk) disable iff (rst)
    !(mem_we && mem_re))
    else $error("stack memory read and write in one cycle");

  a_fin_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == rpn_pkg::S_FIN) |-> (cnt != '0))
    else $error("stack empty after a push");

endmodule

`default_nettype wire
